// ===== hdl/bfa_pkg.sv =====
//------------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit allocator core.
//------------------------------------------------------------------------------
package bfa_pkg;

	localparam int MemoryBytes  = 16777216;
	localparam int HoleEntries  = 32;
	localparam int BlockEntries = 32;
	localparam int LenW = 25;
	localparam int AddrW = 24;
	localparam int HIdxW = $clog2(HoleEntries);
	localparam int BIdxW = $clog2(BlockEntries);
	localparam int HCntW = $clog2(HoleEntries + 1);
	localparam int BCntW = $clog2(BlockEntries + 1);

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_REL   = 2'd1;
	localparam logic [1:0] KIND_SHR   = 2'd2;
	localparam logic [1:0] KIND_XLT   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOMEM = 2'd1;
	localparam logic [1:0] ST_NOTF  = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef enum logic [2:0] {
		CTL_IDLE,
		CTL_EXEC,
		CTL_OUT
	} ctl_state_t;

	// command from controller to datapath
	typedef struct packed {
		logic start;
		logic step;
	} bfa_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic done;
	} bfa_sts_t;

endpackage

// ===== hdl/bfa_ctrl.sv =====
//------------------------------------------------------------------------------
// bfa_ctrl
// Request sequencer: accepts a transaction, runs the datapath until it
// reports done, then presents the result.
//------------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output bfa_cmd_t cmd,
	input  bfa_sts_t sts
);

	ctl_state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CTL_IDLE;
		else state_q <= state_d;
	end

	// advance through request phases
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			CTL_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				cmd.step = 1'b1;
				if (sts.done) state_d = CTL_OUT;
			end
			CTL_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = CTL_IDLE;
			end
			default: state_d = CTL_IDLE;
		endcase
	end

endmodule

// ===== hdl/bfa_dp.sv =====
//------------------------------------------------------------------------------
// bfa_dp
// Allocator datapath: hole and block tables with a micro-sequenced walker
// that scans, shifts and compacts one entry per cycle.
//------------------------------------------------------------------------------
module bfa_dp import bfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bfa_cmd_t          cmd,
	output bfa_sts_t          sts,
	input  logic [1:0]        kind,
	input  logic [LenW-1:0]   size,
	input  logic [31:0]       logical_address,
	input  logic [15:0]       owner,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_data,
	output logic [31:0]       result_logical,
	output logic [AddrW-1:0]  result_physical,
	output logic [1:0]        status,
	output logic [LenW-1:0]   free_bytes
);

	typedef enum logic [4:0] {
		P_DISP, P_CMP, P_BEST, P_BPOS, P_BSH, P_BINS, P_HUPD, P_HDROP, P_LARGE,
		P_FIND, P_FREE, P_HSCAN, P_HMERGE, P_HINS, P_BDROP, P_XLT, P_DONE
	} ph_t;

	localparam logic [LenW-1:0] MemLen = LenW'(MemoryBytes);

	// hole table (registers, walked one entry per cycle)
	logic [AddrW-1:0] hs_q [HoleEntries];
	logic [LenW-1:0]  hl_q [HoleEntries];
	logic [HCntW-1:0] hn_q;
	// block table
	logic [AddrW-1:0] bp_q [BlockEntries];
	logic [31:0]      bl_q [BlockEntries];
	logic [LenW-1:0]  bn_len_q [BlockEntries];
	logic [15:0]      bo_q [BlockEntries];
	logic [BCntW-1:0] bn_q;

	logic [LenW-1:0] empty_q, largest_q;
	logic [31:0]     next_q;

	ph_t             ph_q;
	logic [8:0]      i_q;
	logic [1:0]      kind_q;
	logic [LenW-1:0] size_q;
	logic [31:0]     la_q;
	logic [15:0]     own_q;
	logic [31:0]     rlog_q;
	logic [AddrW-1:0] rphy_q;
	logic [1:0]      st_q;
	logic            found_q;
	logic [HIdxW-1:0] best_q;
	logic [BIdxW-1:0] bidx_q;
	logic [LenW-1:0] run_q;
	logic [AddrW-1:0] off_q;
	logic [AddrW-1:0] fs_q;
	logic [LenW-1:0]  fl_q;
	logic            whole_q;
	logic            pred_f_q, succ_f_q;
	logic [HIdxW-1:0] pred_q, succ_q;
	logic [HCntW-1:0] pos_q;
	logic            pos_f_q;

	logic [HIdxW-1:0] hi;
	logic [BIdxW-1:0] bi;
	logic [AddrW:0]   hend;
	logic [AddrW:0]   frun_end;
	logic [31:0]      xoff;

	assign hi = i_q[HIdxW-1:0];
	assign bi = i_q[BIdxW-1:0];
	assign hend = {1'b0, hs_q[hi]} + {1'b0, hl_q[hi][AddrW-1:0]} +
		{hl_q[hi][AddrW], {AddrW{1'b0}}};
	assign frun_end = {1'b0, fs_q} + {1'b0, fl_q[AddrW-1:0]} + {fl_q[AddrW], {AddrW{1'b0}}};
	assign xoff = la_q - bl_q[bi];

	assign sts.done = (ph_q == P_DONE);
	assign result_logical  = rlog_q;
	assign result_physical = rphy_q;
	assign status          = st_q;
	assign free_bytes      = empty_q;

	// control registers of the walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_DONE;
			hn_q <= HCntW'(1);
			bn_q <= '0;
			empty_q <= MemLen;
			largest_q <= MemLen;
			next_q <= '0;
			hs_q[0] <= '0;
			hl_q[0] <= MemLen;
		end else begin
			if (cfg_we) next_q <= cfg_data;
			if (cmd.start) begin
				ph_q <= P_DISP;
				kind_q <= kind; size_q <= size; la_q <= logical_address; own_q <= owner;
				rlog_q <= '0; rphy_q <= '0; st_q <= ST_OK;
			end else if (cmd.step) begin
				unique case (ph_q)
					P_DISP: begin
						i_q <= '0; found_q <= 1'b0;
						if (kind_q == KIND_ALLOC) begin
							if (size_q == '0 || size_q > empty_q) begin
								st_q <= ST_NOMEM; ph_q <= P_DONE;
							end else if (bn_q >= BCntW'(BlockEntries)) begin
								st_q <= ST_FULL; ph_q <= P_DONE;
							end else if (largest_q <= size_q) begin
								off_q <= '0; ph_q <= P_CMP;
							end else ph_q <= P_BEST;
						end else if (kind_q == KIND_XLT) begin
							st_q <= ST_NOTF; ph_q <= P_XLT;
						end else ph_q <= P_FIND;
					end
					// compaction: repack blocks from zero
					P_CMP: begin
						if (i_q < 9'(bn_q)) begin
							bp_q[bi] <= off_q;
							off_q <= off_q + bn_len_q[bi][AddrW-1:0];
							i_q <= i_q + 9'd1;
						end else begin
							hs_q[0] <= off_q; hl_q[0] <= empty_q;
							hn_q <= (empty_q != '0) ? HCntW'(1) : '0;
							largest_q <= empty_q;
							i_q <= '0; ph_q <= P_BEST;
						end
					end
					// best fit scan
					P_BEST: begin
						if (i_q < 9'(hn_q)) begin
							if (hl_q[hi] >= size_q && (!found_q || hl_q[hi] < hl_q[best_q])) begin
								best_q <= hi; found_q <= 1'b1;
							end
							i_q <= i_q + 9'd1;
						end else if (!found_q) begin
							st_q <= ST_NOMEM; ph_q <= P_DONE;
						end else begin
							rphy_q <= hs_q[best_q]; rlog_q <= next_q;
							i_q <= '0; ph_q <= P_BPOS;
						end
					end
					P_BPOS: begin
						if (i_q < 9'(bn_q) && bp_q[bi] <= rphy_q) i_q <= i_q + 9'd1;
						else begin
							bidx_q <= bi; i_q <= 9'(bn_q); ph_q <= P_BSH;
						end
					end
					P_BSH: begin
						if (i_q > 9'(bidx_q)) begin
							bp_q[bi] <= bp_q[bi-1'b1]; bl_q[bi] <= bl_q[bi-1'b1];
							bn_len_q[bi] <= bn_len_q[bi-1'b1]; bo_q[bi] <= bo_q[bi-1'b1];
							i_q <= i_q - 9'd1;
						end else ph_q <= P_BINS;
					end
					P_BINS: begin
						bp_q[bidx_q] <= rphy_q; bl_q[bidx_q] <= rlog_q;
						bn_len_q[bidx_q] <= size_q; bo_q[bidx_q] <= own_q;
						bn_q <= bn_q + 1'b1;
						next_q <= rlog_q + 32'(size_q);
						empty_q <= empty_q - size_q;
						ph_q <= P_HUPD;
					end
					P_HUPD: begin
						if (hl_q[best_q] == size_q) begin
							i_q <= 9'(best_q); ph_q <= P_HDROP;
						end else begin
							hs_q[best_q] <= hs_q[best_q] + size_q[AddrW-1:0];
							hl_q[best_q] <= hl_q[best_q] - size_q;
							i_q <= '0; run_q <= '0; ph_q <= P_LARGE;
						end
					end
					// close gap in hole table; a freeing request then goes on to the block drop phase
					P_HDROP: begin
						if (i_q + 9'd1 < 9'(hn_q)) begin
							hs_q[hi] <= hs_q[hi+1'b1]; hl_q[hi] <= hl_q[hi+1'b1];
							i_q <= i_q + 9'd1;
						end else begin
							hn_q <= hn_q - 1'b1; i_q <= '0; run_q <= '0;
							ph_q <= (kind_q == KIND_ALLOC) ? P_LARGE : P_BDROP;
						end
					end
					P_LARGE: begin
						if (i_q < 9'(hn_q)) begin
							if (hl_q[hi] > run_q) run_q <= hl_q[hi];
							i_q <= i_q + 9'd1;
						end else begin
							largest_q <= run_q; ph_q <= P_DONE;
						end
					end
					P_FIND: begin
						if (i_q < 9'(bn_q)) begin
							if (bl_q[bi] == la_q) begin
								bidx_q <= bi; ph_q <= P_FREE;
							end else i_q <= i_q + 9'd1;
						end else begin
							st_q <= ST_NOTF; ph_q <= P_DONE;
						end
					end
					P_FREE: begin
						whole_q <= (kind_q == KIND_REL) || size_q == '0;
						if (kind_q == KIND_SHR && size_q != '0 && size_q >= bn_len_q[bidx_q]) begin
							rphy_q <= bp_q[bidx_q]; ph_q <= P_DONE;
						end else begin
							if (kind_q == KIND_REL || size_q == '0) begin
								fs_q <= bp_q[bidx_q]; fl_q <= bn_len_q[bidx_q];
							end else begin
								fs_q <= bp_q[bidx_q] + size_q[AddrW-1:0];
								fl_q <= bn_len_q[bidx_q] - size_q;
							end
							pred_f_q <= 1'b0; succ_f_q <= 1'b0; pos_f_q <= 1'b0;
							pos_q <= hn_q; i_q <= '0; ph_q <= P_HSCAN;
						end
					end
					// find neighbors and insertion point
					P_HSCAN: begin
						if (i_q < 9'(hn_q)) begin
							if (hend == {1'b0, fs_q}) begin pred_f_q <= 1'b1; pred_q <= hi; end
							if ({1'b0, hs_q[hi]} == frun_end) begin succ_f_q <= 1'b1; succ_q <= hi; end
							if (!pos_f_q && hs_q[hi] > fs_q) begin pos_f_q <= 1'b1; pos_q <= HCntW'(hi); end
							i_q <= i_q + 9'd1;
						end else if (!pred_f_q && !succ_f_q && hn_q >= HCntW'(HoleEntries)) begin
							st_q <= ST_FULL; ph_q <= P_DONE;
						end else begin
							rphy_q <= bp_q[bidx_q];
							empty_q <= empty_q + fl_q;
							if (!whole_q) bn_len_q[bidx_q] <= size_q;
							ph_q <= P_HMERGE;
						end
					end
					P_HMERGE: begin
						if (pred_f_q && succ_f_q) begin
							hl_q[pred_q] <= hl_q[pred_q] + fl_q + hl_q[succ_q];
							i_q <= 9'(succ_q); ph_q <= P_HDROP;
						end else begin
							if (pred_f_q) hl_q[pred_q] <= hl_q[pred_q] + fl_q;
							else if (succ_f_q) begin
								hs_q[succ_q] <= fs_q; hl_q[succ_q] <= hl_q[succ_q] + fl_q;
							end
							i_q <= 9'(hn_q);
							ph_q <= (pred_f_q || succ_f_q) ? P_BDROP : P_HINS;
						end
						if (pred_f_q && succ_f_q) whole_q <= whole_q;
					end
					// open gap and insert new hole
					P_HINS: begin
						if (i_q > 9'(pos_q)) begin
							hs_q[hi] <= hs_q[hi-1'b1]; hl_q[hi] <= hl_q[hi-1'b1];
							i_q <= i_q - 9'd1;
						end else begin
							hs_q[hi] <= fs_q; hl_q[hi] <= fl_q;
							hn_q <= hn_q + 1'b1; ph_q <= P_BDROP;
						end
					end
					P_BDROP: begin
						if (!whole_q) begin
							i_q <= '0; run_q <= '0; ph_q <= P_LARGE;
						end else if (9'(bidx_q) + 9'd1 < 9'(bn_q)) begin
							bp_q[bidx_q] <= bp_q[bidx_q+1'b1]; bl_q[bidx_q] <= bl_q[bidx_q+1'b1];
							bn_len_q[bidx_q] <= bn_len_q[bidx_q+1'b1]; bo_q[bidx_q] <= bo_q[bidx_q+1'b1];
							bidx_q <= bidx_q + 1'b1;
						end else begin
							bn_q <= bn_q - 1'b1; i_q <= '0; run_q <= '0; ph_q <= P_LARGE;
						end
					end
					P_XLT: begin
						if (i_q < 9'(bn_q)) begin
							if (xoff < 32'(bn_len_q[bi])) begin
								rphy_q <= bp_q[bi] + xoff[AddrW-1:0];
								st_q <= ST_OK; ph_q <= P_DONE;
							end else i_q <= i_q + 9'd1;
						end else ph_q <= P_DONE;
					end
					P_DONE: ph_q <= P_DONE;
					default: ph_q <= P_DONE;
				endcase
			end
		end
	end

endmodule

// ===== hdl/best_fit_allocator_with_coalescing_core.sv =====
// Compaction, table shifts and scans walk one table entry per cycle over 32-entry
// hole and block tables.
// Throughput: one transaction at a time; next accepted after result taken.
// Reset: asynchronous, active low; one hole of whole memory, no blocks,
// next logical address 0.
//------------------------------------------------------------------------------
// best_fit_allocator_with_coalescing_core
// Top level: joins the request sequencer and the allocator datapath.
//------------------------------------------------------------------------------
module best_fit_allocator_with_coalescing_core import bfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [LenW-1:0]   size,
	input  logic [31:0]       logical_address,
	input  logic [15:0]       owner,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       result_logical,
	output logic [AddrW-1:0]  result_physical,
	output logic [1:0]        status,
	output logic [LenW-1:0]   free_bytes
);

	bfa_cmd_t cmd;
	bfa_sts_t sts;

	assign cfg_ready = 1'b1;

	bfa_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
	);

	bfa_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .kind, .size, .logical_address, .owner,
		.cfg_we(cfg_valid), .cfg_data, .result_logical, .result_physical,
		.status, .free_bytes
	);

endmodule

// ===== tb/sv/best_fit_allocator_with_coalescing_core_test.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// best_fit_allocator_with_coalescing_core_test
// Self-checking bench for the best-fit allocator core. A scoreboard keeps its
// own hole and block tables, predicts each transaction on input acceptance and
// compares every result field. Stimulus runs a directed opening, a scripted
// table-exhaustion sequence and random traffic under several logical bases,
// with random idling on both channels and one long result stall.
//------------------------------------------------------------------------------
module best_fit_allocator_with_coalescing_core_test;
	import bfa_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int LongHold      = 2000;
	localparam int DrainCycles   = 200;

	typedef struct {
		logic [31:0]      lg;
		logic [AddrW-1:0] ph;
		logic [1:0]       st;
		logic [LenW-1:0]  fb;
	} alloc_result_t;

	// predicts allocator results and holds them until the core answers
	class alloc_scoreboard;
		logic [31:0] hole_at[HoleEntries];
		logic [31:0] hole_len[HoleEntries];
		bit          hole_used[HoleEntries];
		logic [31:0] blk_phys[BlockEntries];
		logic [31:0] blk_log[BlockEntries];
		logic [31:0] blk_len[BlockEntries];
		logic [15:0] blk_owner[BlockEntries];
		bit          blk_used[BlockEntries];
		logic [31:0] empty_cnt;
		logic [31:0] largest;
		logic [31:0] next_log;
		logic [31:0] last_log;
		alloc_result_t pending_q[$];
		int errors;

		function new();
			foreach (hole_used[i]) begin
				hole_used[i] = 0;
				hole_at[i]   = 0;
				hole_len[i]  = 0;
			end
			foreach (blk_used[i]) begin
				blk_used[i] = 0;
				blk_len[i]  = 0;
				blk_log[i]  = 0;
				blk_phys[i] = 0;
			end
			hole_used[0] = 1;
			hole_len[0]  = MemoryBytes;
			empty_cnt    = MemoryBytes;
			largest      = MemoryBytes;
			next_log     = 0;
			last_log     = 0;
			errors       = 0;
		endfunction

		function void set_base(logic [31:0] v);
			next_log = v;
		endfunction

		function int hole_count();
			int n;
			n = 0;
			while (n < HoleEntries && hole_used[n]) n++;
			return n;
		endfunction

		function int block_count();
			int n;
			n = 0;
			while (n < BlockEntries && blk_used[n]) n++;
			return n;
		endfunction

		function void drop_hole(int idx);
			int n;
			n = hole_count();
			for (int i = idx; i + 1 < n; i++) begin
				hole_at[i]  = hole_at[i + 1];
				hole_len[i] = hole_len[i + 1];
			end
			if (n > 0) begin
				hole_used[n - 1] = 0;
				hole_at[n - 1]   = 0;
				hole_len[n - 1]  = 0;
			end
		endfunction

		function void update_largest();
			int n;
			n = hole_count();
			largest = 0;
			for (int i = 0; i < n; i++)
				if (hole_len[i] > largest) largest = hole_len[i];
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		// advance the tables by one accepted transaction and queue its result
		function void note_input(logic [1:0] k, logic [LenW-1:0] sz, logic [31:0] la,
				logic [15:0] own);
			alloc_result_t r;
			int n, nh, best, pos, b, pred, succ;
			bit found, whole;
			logic [31:0] s32, ps, len, keep, fs, fl, off;
			r.lg = 0;
			r.ph = 0;
			r.st = ST_OK;
			s32 = 32'(sz);
			case (k)
				KIND_ALLOC: begin
					n = block_count();
					if (s32 == 0 || s32 > empty_cnt) begin
						r.st = ST_NOMEM;
					end else if (n >= BlockEntries) begin
						r.st = ST_FULL;
					end else begin
						// compact: pack blocks from zero, one hole at the end
						if (largest <= s32) begin
							off = 0;
							for (int i = 0; i < n; i++) begin
								blk_phys[i] = off;
								off += blk_len[i];
							end
							foreach (hole_used[i]) begin
								hole_used[i] = 0;
								hole_at[i]   = 0;
								hole_len[i]  = 0;
							end
							if (empty_cnt > 0) begin
								hole_used[0] = 1;
								hole_at[0]   = off;
								hole_len[0]  = empty_cnt;
							end
							largest = empty_cnt;
						end
						nh = hole_count();
						found = 0;
						best = 0;
						for (int i = 0; i < nh; i++)
							if (hole_len[i] >= s32 && (!found || hole_len[i] < hole_len[best])) begin
								best = i;
								found = 1;
							end
						if (!found) begin
							r.st = ST_NOMEM;
						end else begin
							ps = hole_at[best];
							r.ph = AddrW'(ps);
							r.lg = next_log;
							pos = n;
							for (int i = 0; i < n; i++)
								if (blk_phys[i] > ps) begin
									pos = i;
									break;
								end
							for (int i = n; i > pos; i--) begin
								blk_phys[i]  = blk_phys[i - 1];
								blk_log[i]   = blk_log[i - 1];
								blk_len[i]   = blk_len[i - 1];
								blk_owner[i] = blk_owner[i - 1];
							end
							blk_phys[pos]  = ps;
							blk_log[pos]   = r.lg;
							blk_len[pos]   = s32;
							blk_owner[pos] = own;
							blk_used[n]    = 1;
							if (hole_len[best] == s32) begin
								drop_hole(best);
							end else begin
								hole_at[best]  += s32;
								hole_len[best] -= s32;
							end
							next_log = r.lg + s32;
							last_log = r.lg;
							empty_cnt -= s32;
							update_largest();
						end
					end
				end
				KIND_REL, KIND_SHR: begin
					n = block_count();
					b = -1;
					for (int i = 0; i < n; i++)
						if (b < 0 && blk_log[i] == la) b = i;
					if (b < 0) begin
						r.st = ST_NOTF;
					end else begin
						ps = blk_phys[b];
						len = blk_len[b];
						whole = (k == KIND_REL) || s32 == 0;
						if (!whole && s32 >= len) begin
							r.ph = AddrW'(ps);
						end else begin
							keep = whole ? 0 : s32;
							fs = ps + keep;
							fl = len - keep;
							nh = hole_count();
							pred = -1;
							succ = -1;
							pos = nh;
							for (int i = 0; i < nh; i++) begin
								if (hole_at[i] + hole_len[i] == fs) pred = i;
								if (hole_at[i] == fs + fl) succ = i;
								if (pos == nh && hole_at[i] > fs) pos = i;
							end
							if (nh >= HoleEntries && pred < 0 && succ < 0) begin
								r.st = ST_FULL;
							end else begin
								r.ph = AddrW'(ps);
								if (whole) begin
									for (int i = b; i + 1 < n; i++) begin
										blk_phys[i]  = blk_phys[i + 1];
										blk_log[i]   = blk_log[i + 1];
										blk_len[i]   = blk_len[i + 1];
										blk_owner[i] = blk_owner[i + 1];
									end
									blk_used[n - 1] = 0;
									blk_phys[n - 1] = 0;
									blk_log[n - 1]  = 0;
									blk_len[n - 1]  = 0;
								end else begin
									blk_len[b] = keep;
								end
								// merge the freed run with its neighbors
								if (pred >= 0 && succ >= 0) begin
									hole_len[pred] += fl + hole_len[succ];
									drop_hole(succ);
								end else if (pred >= 0) begin
									hole_len[pred] += fl;
								end else if (succ >= 0) begin
									hole_at[succ] = fs;
									hole_len[succ] += fl;
								end else begin
									for (int i = nh; i > pos; i--) begin
										hole_at[i]  = hole_at[i - 1];
										hole_len[i] = hole_len[i - 1];
									end
									hole_at[pos]  = fs;
									hole_len[pos] = fl;
									hole_used[nh] = 1;
								end
								empty_cnt += fl;
								update_largest();
							end
						end
					end
				end
				default: begin
					n = block_count();
					r.st = ST_NOTF;
					for (int i = 0; i < n; i++) begin
						off = la - blk_log[i];
						if (off < blk_len[i]) begin
							r.ph = AddrW'(blk_phys[i] + off);
							r.st = ST_OK;
							break;
						end
					end
				end
			endcase
			r.fb = LenW'(empty_cnt);
			pending_q.push_back(r);
		endfunction

		function void check_result(alloc_result_t got);
			alloc_result_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result lg %h ph %h st %0d fb %h", $time,
					got.lg, got.ph, got.st, got.fb);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (got.lg !== e.lg) begin
				$display("%0t: result_logical expected %h actual %h", $time, e.lg, got.lg);
				errors++;
			end
			if (got.ph !== e.ph) begin
				$display("%0t: result_physical expected %h actual %h", $time, e.ph, got.ph);
				errors++;
			end
			if (got.st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, got.st);
				errors++;
			end
			if (got.fb !== e.fb) begin
				$display("%0t: free_bytes expected %h actual %h", $time, e.fb, got.fb);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [31:0]      cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       kind;
	logic [LenW-1:0]  size;
	logic [31:0]      logical_address;
	logic [15:0]      owner;
	logic             out_valid;
	logic             out_ready;
	logic [31:0]      result_logical;
	logic [AddrW-1:0] result_physical;
	logic [1:0]       status;
	logic [LenW-1:0]  free_bytes;

	alloc_scoreboard sb = new();
	bit hold_req = 0;
	int stall_cycles = 0;
	logic [31:0] seq_log[BlockEntries];

	best_fit_allocator_with_coalescing_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.size            (size),
		.logical_address (logical_address),
		.owner           (owner),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_logical  (result_logical),
		.result_physical (result_physical),
		.status          (status),
		.free_bytes      (free_bytes)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, some none, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// observe handshakes at the rising edge; predict on accept, check on result
	always @(posedge clk) begin
		alloc_result_t got;
		bit moved;
		moved = 0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_input(kind, size, logical_address, owner);
				moved = 1;
			end
			if (out_valid && out_ready) begin
				got.lg = result_logical;
				got.ph = result_physical;
				got.st = status;
				got.fb = free_bytes;
				sb.check_result(got);
				moved = 1;
			end
			if (cfg_valid && cfg_ready) moved = 1;
			stall_cycles <= moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= WatchdogLimit) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// result side: random back-pressure plus one long hold on request
	initial begin
		int n;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 0;
				repeat (LongHold) @(negedge clk);
			end
			n = gap_len();
			if (n > 0) begin
				out_ready <= 0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1;
			repeat ($urandom_range(1, 8) - 1) @(negedge clk);
		end
	end

	// drive one transaction; called at a falling edge, returns at one
	task automatic send(logic [1:0] k, logic [LenW-1:0] sz, logic [31:0] la,
			logic [15:0] own);
		int g;
		in_valid <= 1;
		kind <= k;
		size <= sz;
		logical_address <= la;
		owner <= own;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic write_base(logic [31:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_base(v);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	// hold until every result is back, then let the core settle
	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic release_all();
		while (sb.block_count() > 0) send(KIND_REL, 0, sb.blk_log[0], 0);
	endtask

	// random transaction drawn from the live block table
	task automatic random_item();
		int r, n, idx;
		logic [31:0] la;
		logic [LenW-1:0] sz;
		r = $urandom_range(99);
		n = sb.block_count();
		idx = (n > 0) ? $urandom_range(n - 1) : 0;
		la = (n > 0) ? sb.blk_log[idx] : $urandom;
		if (r < 45) begin
			r = $urandom_range(99);
			if (r < 70) sz = LenW'($urandom_range(1, 4096));
			else if (r < 85) sz = LenW'($urandom_range(1, 1 << 20));
			else if (r < 92) sz = LenW'($urandom_range(0, sb.empty_cnt));
			else if (r < 96) sz = LenW'(MemoryBytes);
			else sz = LenW'($urandom_range(0, MemoryBytes));
			send(KIND_ALLOC, sz, $urandom, 16'($urandom));
		end else if (r < 70) begin
			if ($urandom_range(9) == 0) la = $urandom;
			send(KIND_REL, LenW'($urandom_range(0, MemoryBytes)), la, 16'($urandom));
		end else if (r < 85) begin
			sz = ($urandom_range(3) == 0 || n == 0) ? '0 :
				LenW'($urandom_range(0, sb.blk_len[idx]));
			if ($urandom_range(9) == 0) sz = LenW'($urandom_range(0, MemoryBytes));
			send(KIND_SHR, sz, la, 16'($urandom));
		end else begin
			if (n > 0 && $urandom_range(4) != 0)
				la = sb.blk_log[idx] + $urandom_range(0, sb.blk_len[idx]);
			else
				la = $urandom;
			send(KIND_XLT, LenW'($urandom_range(0, MemoryBytes)), la, 16'($urandom));
		end
	endtask

	// fill both tables: 32 blocks, then 32 holes, then one free that fits nowhere
	task automatic exhaust_tables();
		logic [31:0] x_log;
		release_all();
		send(KIND_ALLOC, 1, 0, 16'h1234);
		x_log = sb.last_log;
		for (int i = 0; i < 30; i++) begin
			send(KIND_ALLOC, 8, 0, 16'(i));
			seq_log[i] = sb.last_log;
		end
		send(KIND_REL, 0, x_log, 0);
		send(KIND_ALLOC, 8, 0, 16'hffff);
		seq_log[30] = sb.last_log;
		send(KIND_ALLOC, 8, 0, 16'h0);
		send(KIND_ALLOC, 1, 0, 16'h5a5a);
		for (int i = 0; i < 30; i++) send(KIND_SHR, 4, seq_log[i], 0);
		send(KIND_SHR, 4, seq_log[30], 0);
		send(KIND_XLT, 0, seq_log[30] + 3, 0);
		release_all();
	endtask

	initial begin
		logic [31:0] la_a, la_b, la_c;
		logic [31:0] bases[4];
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = 0;
		in_valid = 0;
		kind = KIND_ALLOC;
		size = 0;
		logical_address = 0;
		owner = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed opening: wrap of the logical counter, edge sizes, compaction
		write_base(32'hffff_fff0);
		send(KIND_ALLOC, 0, 0, 0);
		send(KIND_ALLOC, LenW'(MemoryBytes), 0, 16'hffff);
		la_a = sb.last_log;
		send(KIND_XLT, 0, la_a + 32'h00ff_ffff, 0);
		send(KIND_XLT, 0, la_a - 1, 0);
		send(KIND_ALLOC, 1, 0, 0);
		send(KIND_SHR, LenW'(MemoryBytes), la_a, 0);
		send(KIND_SHR, 0, la_a, 0);
		send(KIND_REL, 0, 32'hdead_beef, 0);
		send(KIND_ALLOC, 25'h080_0000, 0, 16'h0001);
		la_a = sb.last_log;
		send(KIND_ALLOC, 25'h040_0000, 0, 16'h0002);
		la_b = sb.last_log;
		send(KIND_ALLOC, 25'h040_0000, 0, 16'h0003);
		la_c = sb.last_log;
		send(KIND_ALLOC, 1, 0, 0);
		send(KIND_REL, 0, la_a, 0);
		send(KIND_REL, 0, la_c, 0);
		send(KIND_ALLOC, 25'h0a0_0000, 32'hffff_ffff, 16'h0004);
		send(KIND_XLT, 0, la_b + 5, 0);
		send(KIND_SHR, 25'h000_1000, la_b, 0);
		send(KIND_SHR, LenW'(25'h1ff_ffff & MemoryBytes), la_b, 0);
		release_all();
		in_valid <= 0;
		drain();

		bases[0] = 0;
		bases[1] = 32'hffff_ffff;
		bases[2] = $urandom;
		bases[3] = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			write_base(bases[ph]);
			if (ph == 1) hold_req = 1;
			if (ph == 2) exhaust_tables();
			for (int i = 0; i < 350; i++) random_item();
			in_valid <= 0;
			drain();
		end

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
